>>> sv/swpi_pkg.sv
// shared types and constants for the stack with positional insert
// no dependencies
package swpi_pkg;

  localparam int DATA_W    = 32;
  localparam int POS_W     = 5;
  localparam int FILL_W    = 5;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_POP     = 2'd1,
    REQ_INSERT  = 2'd2,
    REQ_REPLACE = 2'd3
  } req_t;

  // broadcast to every cell; ins also covers push (slot index zero)
  typedef struct packed {
    logic              ins;
    logic              pop;
    logic              rep;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] new_value;
  } cell_cmd_t;

endpackage

>>> sv/stack_with_positional_insert_unit.sv
// top level of the bounded stack with positional insert and replace-all
// depends on swpi_pkg and swpi_cell
//
// usage: drive req_type, value, position and new_value with start high; a
// request word is taken at every clock edge where start is high and busy is
// low. busy is always low: the block takes one request word per cycle.
// each request gives exactly one result word (data, ok, fill_level) on the
// cycle after it was taken, marked by done for that single cycle. the
// receiver cannot stall, so results are never held back.
// throughput: 1 request per cycle, set by the row of
// cells, which all update in the same edge.
// storage is a row of DEPTH cells with the top entry in cell 0: push and
// insert shift the cells below the slot one step away from the top, pop
// shifts everything one step toward the top, replace compares in every cell.
// reset clears the fill count and done; cell contents stay undefined, and
// only cells below the fill count are ever read.
module stack_with_positional_insert_unit #(
  parameter int DEPTH = swpi_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type,
  input  logic signed [swpi_pkg::DATA_W-1:0] value,
  input  logic [swpi_pkg::POS_W-1:0]    position,
  input  logic signed [swpi_pkg::DATA_W-1:0] new_value,
  output logic                          done,
  output logic signed [swpi_pkg::DATA_W-1:0] data,
  output logic                          ok,
  output logic [swpi_pkg::FILL_W-1:0]   fill_level
);
  import swpi_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     slot;
  logic              accept;
  logic              req_ok;
  logic              is_empty;
  logic              is_full;
  logic              pos_bad;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] entries [DEPTH];
  req_t              req;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign req    = req_t'(req_type);

  assign is_empty = (count == '0);
  assign is_full  = (count == FULL);
  // position is compared at the wider of the two widths
  assign pos_bad  = (CMPW'(position) > CMPW'(count));

  always_comb begin
    req_ok     = 1'b1;
    count_next = count;
    slot       = '0;
    cmd        = '0;
    cmd.value     = value;
    cmd.new_value = new_value;
    case (req)
      REQ_PUSH: begin
        req_ok     = !is_full;
        count_next = count + CW'(1);
        cmd.ins    = accept && req_ok;
      end
      REQ_POP: begin
        req_ok     = !is_empty;
        count_next = count - CW'(1);
        cmd.pop    = accept && req_ok;
      end
      REQ_INSERT: begin
        req_ok     = !pos_bad && !is_full;
        count_next = count + CW'(1);
        // slot counted from the top: entries below it move away from the top
        slot       = count - CW'(position);
        cmd.ins    = accept && req_ok;
      end
      REQ_REPLACE: begin
        cmd.rep = accept;
      end
      default: begin
        req_ok = 1'b0;
      end
    endcase
    if (!req_ok) begin
      count_next = count;
    end
  end

  // row of cells, each fed by its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] above;
    logic [DATA_W-1:0] below;
    if (i == 0) begin : g_top
      assign above = value;
    end else begin : g_mid
      assign above = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_low
      assign below = entries[i+1];
    end
    swpi_cell #(
      .INDEX(i),
      .CW   (CW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .slot      (slot),
      .count     (count),
      .from_above(above),
      .from_below(below),
      .entry     (entries[i])
    );
  end

  // fill count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // result word; fill level shows the count modulo 2**FILL_W
  always_ff @(posedge clk) begin
    if (accept) begin
      ok         <= req_ok;
      data       <= (cmd.pop) ? entries[0] : '0;
      fill_level <= FILL_W'(CMPW'(count_next));
    end
  end

  // count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("fill count above depth");

  // a refused request leaves the count alone
  a_fail_hold: assert property (@(posedge clk) disable iff (rst)
    accept && !req_ok |=> count == $past(count))
    else $error("count moved on a refused request");

  // a result strobe follows in the cycle after every accepted request
  a_done: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("missing result strobe");

  // a successful pop takes exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> count == $past(count) - CW'(1))
    else $error("pop did not drop the count by one");

endmodule

>>> sv/swpi_cell.sv
// one storage cell of the shifting stack; cell 0 holds the top entry
// depends on swpi_pkg
module swpi_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  logic                      clk,
  input  swpi_pkg::cell_cmd_t       cmd,
  input  logic [CW-1:0]             slot,
  input  logic [CW-1:0]             count,
  input  logic [swpi_pkg::DATA_W-1:0] from_above,
  input  logic [swpi_pkg::DATA_W-1:0] from_below,
  output logic [swpi_pkg::DATA_W-1:0] entry
);
  import swpi_pkg::*;

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      // cells deeper than the slot move one step away from the top
      if (IDX > slot) begin
        entry <= from_above;
      end else if (IDX == slot) begin
        entry <= cmd.value;
      end
    end else if (cmd.pop) begin
      entry <= from_below;
    end else if (cmd.rep && (IDX < count) && (entry == cmd.value)) begin
      entry <= cmd.new_value;
    end
  end

endmodule

>>> bench/stack_with_positional_insert_unit_tb.sv
// self-checking bench for stack_with_positional_insert_unit: directed and random
// request words, a cycle-accurate stack predictor and an in-order result check
// depends on swpi_pkg and the rtl of the stack unit
`timescale 1ns / 1ps

module stack_with_positional_insert_unit_tb;
  import swpi_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int RANDOM_WORDS = 1200;
  localparam int WORDS_PER_PHASE = 300;
  localparam int CYCLE_LIMIT = 200000;
  // the unit answers in the cycle after it takes a word; spare cycles follow at the end
  localparam int DRAIN_CYCLES = 4;

  // one request word as the sender holds it, plus the idle chance while it waits
  typedef struct {
    req_t                     kind;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] new_value;
    int unsigned              idle_pct;
  } request_word_t;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic                     ok;
    logic [FILL_W-1:0]        fill_level;
  } result_word_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [1:0]               req_type = REQ_PUSH;
  logic signed [DATA_W-1:0] value = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] new_value = '0;
  logic                     busy;
  logic                     done;
  logic signed [DATA_W-1:0] data;
  logic                     ok;
  logic [FILL_W-1:0]        fill_level;

  stack_with_positional_insert_unit #(
    .DEPTH(STACK_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .value(value),
    .position(position),
    .new_value(new_value),
    .done(done),
    .data(data),
    .ok(ok),
    .fill_level(fill_level)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  request_word_t request_backlog[$];
  result_word_t  expected_results[$];
  request_word_t word_on_ports;
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;

  // predictor state: index 0 is the bottom entry
  logic signed [DATA_W-1:0] stack_words[STACK_DEPTH];
  int                       stack_count = 0;

  // stimulus-side bookkeeping: fill count only, plus recently stored values
  // so that replace words find matches
  int                       planned_count = 0;
  logic signed [DATA_W-1:0] recent_words[$];

  // runs one request word against the predicted stack and gives its result word
  function automatic result_word_t apply_request(request_word_t req);
    result_word_t res;
    int           slot;
    res.data = '0;
    res.ok   = 1'b1;
    case (req.kind)
      REQ_PUSH: begin
        if (stack_count >= STACK_DEPTH) begin
          res.ok = 1'b0;
        end else begin
          stack_words[stack_count] = req.value;
          stack_count++;
        end
      end
      REQ_POP: begin
        if (stack_count == 0) begin
          res.ok = 1'b0;
        end else begin
          stack_count--;
          res.data = stack_words[stack_count];
        end
      end
      REQ_INSERT: begin
        // a position past the count fails even when the stack is also full
        if (int'(req.position) > stack_count || stack_count >= STACK_DEPTH) begin
          res.ok = 1'b0;
        end else begin
          for (slot = stack_count; slot > int'(req.position); slot--)
            stack_words[slot] = stack_words[slot-1];
          stack_words[req.position] = req.value;
          stack_count++;
        end
      end
      default: begin
        // replace all matches; an empty stack or no match still succeeds
        for (slot = 0; slot < stack_count; slot++)
          if (stack_words[slot] == req.value) stack_words[slot] = req.new_value;
      end
    endcase
    res.fill_level = stack_count[FILL_W-1:0];
    return res;
  endfunction

  // extremes, a narrow band around zero for replace hits, and full-range noise
  function automatic logic signed [DATA_W-1:0] pick_operand();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return '0;
        default: return -1;
      endcase
    end else if (roll <= 3) begin
      return $signed($urandom_range(0, 8)) - 4;
    end
    return $urandom;
  endfunction

  task automatic queue_request(req_t kind, logic signed [DATA_W-1:0] val,
                               logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] nval,
                               int unsigned idle_pct);
    request_word_t req;
    logic          stored;
    req.kind      = kind;
    req.value     = val;
    req.position  = pos;
    req.new_value = nval;
    req.idle_pct  = idle_pct;
    request_backlog.push_back(req);
    // track the fill count so the random part can steer between full and empty
    stored = 1'b0;
    case (kind)
      REQ_PUSH:   stored = (planned_count < STACK_DEPTH);
      REQ_INSERT: stored = (int'(pos) <= planned_count && planned_count < STACK_DEPTH);
      REQ_POP:    if (planned_count > 0) planned_count--;
      default:    ;
    endcase
    if (stored) begin
      planned_count++;
      recent_words.push_back(val);
      if (recent_words.size() > STACK_DEPTH) void'(recent_words.pop_front());
    end
  endtask

  task automatic build_stimulus();
    int unsigned              idle_by_phase[4];
    int unsigned              idle;
    int unsigned              roll;
    int                       n;
    bit                       filling;
    req_t                     kind;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] nval;
    // no gaps, heavy sender gaps, no gaps again, light sender gaps
    idle_by_phase = '{0, 85, 0, 23};

    // empty-stack corners: pop fails, replace succeeds, insert past count fails
    queue_request(REQ_POP, 0, 0, 0, 0);
    queue_request(REQ_REPLACE, 5, 0, 6, 0);
    queue_request(REQ_INSERT, 9, 1, 0, 0);
    // insert at bottom of an empty stack, then extremes on top
    queue_request(REQ_INSERT, 32'sh7fff_ffff, 0, 0, 0);
    queue_request(REQ_PUSH, 32'sh8000_0000, 0, 0, 0);
    queue_request(REQ_PUSH, 0, 0, 0, 0);
    // insert at position equal to the count behaves as a push
    queue_request(REQ_INSERT, -1, 3, 0, 0);
    // insert in the middle shifts the upper entries
    queue_request(REQ_INSERT, 32'sh5555_5555, 1, 0, 0);
    queue_request(REQ_REPLACE, 0, 0, 32'shAAAA_AAAA, 0);
    // fill to the top with repeating small values
    for (n = 0; n < 11; n++) queue_request(REQ_PUSH, (n % 3) - 1, 0, 0, 0);
    // full-stack corners, including insert past the count while full
    queue_request(REQ_PUSH, 77, 0, 0, 0);
    queue_request(REQ_INSERT, 78, 2, 0, 0);
    queue_request(REQ_INSERT, 79, 31, 0, 0);
    // replace with several matches, then replace a value with itself
    queue_request(REQ_REPLACE, 1, 0, 7, 0);
    queue_request(REQ_REPLACE, -1, 0, -1, 0);

    filling = 1'b0;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      idle = idle_by_phase[(n / WORDS_PER_PHASE) % 4];
      // turn around at the ends, after a few tries against full or empty
      if (planned_count >= STACK_DEPTH && $urandom_range(0, 99) < 30) filling = 1'b0;
      if (planned_count == 0 && $urandom_range(0, 99) < 30) filling = 1'b1;
      roll = $urandom_range(0, 99);
      if (filling)
        kind = (roll < 35) ? REQ_PUSH : (roll < 65) ? REQ_INSERT :
               (roll < 80) ? REQ_POP : REQ_REPLACE;
      else
        kind = (roll < 50) ? REQ_POP : (roll < 65) ? REQ_PUSH :
               (roll < 80) ? REQ_INSERT : REQ_REPLACE;
      // mostly legal insert positions, some just past the count, some anywhere
      roll = $urandom_range(0, 99);
      if (roll < 80)      pos = $urandom_range(0, planned_count);
      else if (roll < 90) pos = $urandom_range(planned_count + 1, 31);
      else                pos = $urandom_range(0, 31);
      if (kind == REQ_REPLACE && recent_words.size() != 0 && $urandom_range(0, 99) < 60)
        val = recent_words[$urandom_range(0, recent_words.size() - 1)];
      else
        val = pick_operand();
      nval = ($urandom_range(0, 99) < 15) ? val : pick_operand();
      queue_request(kind, val, pos, nval, idle);
    end
  endtask

  // sender: a word on the ports is taken at an edge with start high and busy low;
  // the next word is put up at the same edge unless this cycle is an idle one
  always @(posedge clk) begin : drive_requests
    request_word_t upcoming;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) expected_results.push_back(apply_request(word_on_ports));
      if (request_backlog.size() != 0 &&
          $urandom_range(0, 99) >= request_backlog[0].idle_pct) begin
        upcoming      = request_backlog.pop_front();
        word_on_ports = upcoming;
        start     <= 1'b1;
        req_type  <= upcoming.kind;
        value     <= upcoming.value;
        position  <= upcoming.position;
        new_value <= upcoming.new_value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // receiver: done marks a result word for exactly one cycle, never held back
  always @(posedge clk) begin : check_results
    result_word_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: data %0d ok %0b fill_level %0d",
               data, ok, fill_level);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (data !== want.data) begin
          $error("data: expected %0d, got %0d", want.data, data);
          fail_count++;
        end
        if (ok !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, ok);
          fail_count++;
        end
        if (fill_level !== want.fill_level) begin
          $error("fill_level: expected %0d, got %0d", want.fill_level, fill_level);
          fail_count++;
        end
      end
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // wait until every word is taken and every result has come back
    while (request_backlog.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    // stray result words would show up in these cycles
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d result words never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
